// File: hdl/vitk7_pkg.sv
// Shared types and constants for the K=7 rate one-half Viterbi decoder.
// Has no dependencies; the controller, datapath, core and testbench refer to it by scoped names.
`default_nettype none
package vitk7_pkg;

  localparam int NST        = 64;
  localparam int ST_W       = 6;
  localparam int SAMPLE_W   = 8;
  localparam int GAIN_W     = 7;
  localparam int SQ_W       = 16;
  localparam int BM_W       = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAPS_NEG = 1'd1;
  localparam logic [GAIN_W-1:0]    GAIN_RESET = 7'd64;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQ    = 7'b0000010,
    S_BM    = 7'b0000100,
    S_ACS   = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_TB    = 7'b0100000,
    S_DONE  = 7'b1000000
  } ctrl_state_t;

  typedef struct packed {
    logic            accept;
    logic            sq;
    logic            bm;
    logic            acs_valid;
    logic [ST_W-1:0] acs_state;
    logic            acs_done;
    logic            tb_step;
    logic            out_load;
  } dp_cmd_t;

  // First code bit for predecessor p and information bit u.
  function automatic logic code1(input logic [ST_W-1:0] p, input logic u);
    return u ^ p[1] ^ p[2] ^ p[4] ^ p[5];
  endfunction

  // Second code bit for predecessor p and information bit u.
  function automatic logic code2(input logic [ST_W-1:0] p, input logic u);
    return u ^ p[0] ^ p[1] ^ p[2] ^ p[5];
  endfunction

endpackage
`default_nettype wire

// File: hdl/vitk7_in_if.sv
// Input channel of the Viterbi decoder: valid/ready handshake with an I/Q pair.
// Standalone; no package dependency.
`default_nettype none
interface vitk7_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] i_sample;
  logic signed [7:0] q_sample;
  modport source (output valid, output i_sample, output q_sample, input ready);
  modport sink (input valid, input i_sample, input q_sample, output ready);
endinterface
`default_nettype wire

// File: hdl/vitk7_out_if.sv
// Result channel of the Viterbi decoder: valid/ready handshake with one decoded bit.
// Standalone; no package dependency.
`default_nettype none
interface vitk7_out_if;
  logic valid;
  logic ready;
  logic decoded_bit;
  modport source (output valid, output decoded_bit, input ready);
  modport sink (input valid, input decoded_bit, output ready);
endinterface
`default_nettype wire

// File: hdl/vitk7_ctrl.sv
// Sequencer of the Viterbi decoder: walks one symbol through metrics, ACS and traceback.
// Depends on vitk7_pkg for the state enum and the command struct.
`default_nettype none
module vitk7_ctrl #(
  parameter int TRACEBACK_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output vitk7_pkg::dp_cmd_t     cmd
);

  localparam int TBC_W = $clog2(TRACEBACK_DEPTH + 1);
  // Last drain count, reached once the final ACS metric write and min update are done.
  localparam logic [vitk7_pkg::ST_W-1:0] DRAIN_LAST = 6'd3;
  localparam logic [vitk7_pkg::ST_W-1:0] ACS_LAST = 6'd63;

  vitk7_pkg::ctrl_state_t state_r, state_nxt;
  logic [vitk7_pkg::ST_W-1:0] cnt_r, cnt_nxt;
  logic [TBC_W-1:0] tb_cnt_r, tb_cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    tb_cnt_nxt    = tb_cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      vitk7_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = vitk7_pkg::S_SQ;
        end
      end
      vitk7_pkg::S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = vitk7_pkg::S_BM;
      end
      vitk7_pkg::S_BM: begin
        cmd.bm    = 1'b1;
        cnt_nxt   = '0;
        state_nxt = vitk7_pkg::S_ACS;
      end
      vitk7_pkg::S_ACS: begin
        cmd.acs_valid = 1'b1;
        cmd.acs_state = cnt_r;
        if (cnt_r == ACS_LAST) begin
          cnt_nxt   = '0;
          state_nxt = vitk7_pkg::S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      vitk7_pkg::S_DRAIN: begin
        if (cnt_r == DRAIN_LAST) begin
          cmd.acs_done = 1'b1;
          tb_cnt_nxt   = '0;
          state_nxt    = vitk7_pkg::S_TB;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      vitk7_pkg::S_TB: begin
        cmd.tb_step = 1'b1;
        if (tb_cnt_r == TBC_W'(TRACEBACK_DEPTH - 1)) begin
          state_nxt = vitk7_pkg::S_DONE;
        end else begin
          tb_cnt_nxt = tb_cnt_r + 1'b1;
        end
      end
      vitk7_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = vitk7_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = vitk7_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vitk7_pkg::S_IDLE;
      cnt_r       <= '0;
      tb_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tb_cnt_r    <= tb_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: hdl/vitk7_dp.sv
// Datapath of the Viterbi decoder: branch metrics, pipelined ACS unit, metric and
// survivor memories, traceback and result register. Depends on vitk7_pkg.
`default_nettype none
module vitk7_dp #(
  parameter int TRACEBACK_DEPTH = 64,
  parameter int METRIC_WIDTH    = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire vitk7_pkg::dp_cmd_t                  cmd,
  input  wire logic signed [vitk7_pkg::SAMPLE_W-1:0] in_i,
  input  wire logic signed [vitk7_pkg::SAMPLE_W-1:0] in_q,
  input  wire logic                                cfg_we,
  input  wire logic [vitk7_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [vitk7_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                                     out_bit
);

  localparam int RW   = $clog2(TRACEBACK_DEPTH);
  localparam int SW   = vitk7_pkg::ST_W;
  localparam int MW   = METRIC_WIDTH;
  localparam int SQW  = vitk7_pkg::SQ_W;
  localparam int BMW  = vitk7_pkg::BM_W;
  localparam int DW   = vitk7_pkg::SAMPLE_W + 2;

  // Configuration registers.
  logic [vitk7_pkg::GAIN_W-1:0] gain_r;
  logic neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= vitk7_pkg::GAIN_RESET;
      neg_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        vitk7_pkg::REG_SIGNAL_GAIN:  gain_r <= cfg_wdata;
        vitk7_pkg::REG_ONE_MAPS_NEG: neg_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sample capture, squared distances to +gain and -gain, then the four branch metrics.
  logic signed [vitk7_pkg::SAMPLE_W-1:0] i_r, q_r;
  logic signed [DW-1:0] di_p, di_n, dq_p, dq_n;
  logic signed [2*DW-1:0] pr_ip, pr_in, pr_qp, pr_qn;
  logic [SQW-1:0] sq_ip_r, sq_in_r, sq_qp_r, sq_qn_r;
  logic [BMW-1:0] bm_r [4];

  assign di_p  = DW'(i_r) - DW'({1'b0, gain_r});
  assign di_n  = DW'(i_r) + DW'({1'b0, gain_r});
  assign dq_p  = DW'(q_r) - DW'({1'b0, gain_r});
  assign dq_n  = DW'(q_r) + DW'({1'b0, gain_r});
  assign pr_ip = di_p * di_p;
  assign pr_in = di_n * di_n;
  assign pr_qp = dq_p * dq_p;
  assign pr_qn = dq_n * dq_n;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      i_r <= in_i;
      q_r <= in_q;
    end
    if (cmd.sq) begin
      sq_ip_r <= pr_ip[SQW-1:0];
      sq_in_r <= pr_in[SQW-1:0];
      sq_qp_r <= pr_qp[SQW-1:0];
      sq_qn_r <= pr_qn[SQW-1:0];
    end
    if (cmd.bm) begin
      for (int s = 0; s < 4; s++) begin
        // A code bit equal to neg_r is sent at minus gain.
        bm_r[s] <= BMW'((s[0] == neg_r) ? sq_in_r : sq_ip_r)
                 + BMW'((s[1] == neg_r) ? sq_qn_r : sq_qp_r);
      end
    end
  end

  // Path metrics: two banks, read from one while the other is written.
  logic [MW-1:0] pm_mem [2*vitk7_pkg::NST];
  logic bank_r;
  logic fresh_r;
  logic [MW-1:0] min_prev_r, min_acc_r;
  logic [RW-1:0] row_r;
  logic [TRACEBACK_DEPTH-1:0] row_valid_r;

  // Stage 1: registered metric reads.
  logic [MW-1:0] pm0_s1_r, pm1_s1_r;
  logic [SW-1:0] ns_s1_r;
  logic v_s1_r;
  // Stage 2: normalized metrics.
  logic [MW-1:0] a0_s2_r, a1_s2_r;
  logic [SW-1:0] ns_s2_r;
  logic v_s2_r;
  // Stage 3: selected metric.
  logic [MW-1:0] nx_s3_r;
  logic [SW-1:0] ns_s3_r;
  logic v_s3_r;

  always_ff @(posedge clk) begin
    if (cmd.acs_valid) begin
      pm0_s1_r <= pm_mem[{bank_r, 1'b0, cmd.acs_state[SW-1:1]}];
      pm1_s1_r <= pm_mem[{bank_r, 1'b1, cmd.acs_state[SW-1:1]}];
    end
    ns_s1_r <= cmd.acs_state;
    a0_s2_r <= fresh_r ? '0 : pm0_s1_r - min_prev_r;
    a1_s2_r <= fresh_r ? '0 : pm1_s1_r - min_prev_r;
    ns_s2_r <= ns_s1_r;
  end

  logic [SW-1:0] p0, p1;
  logic [MW:0] sum0, sum1;
  logic [MW-1:0] cand0, cand1, sel_pm;
  logic take_low;

  always_comb begin
    p0    = {1'b0, ns_s2_r[SW-1:1]};
    p1    = {1'b1, ns_s2_r[SW-1:1]};
    sum0  = {1'b0, a0_s2_r} + (MW+1)'(bm_r[{vitk7_pkg::code2(p0, ns_s2_r[0]),
                                            vitk7_pkg::code1(p0, ns_s2_r[0])}]);
    sum1  = {1'b0, a1_s2_r} + (MW+1)'(bm_r[{vitk7_pkg::code2(p1, ns_s2_r[0]),
                                            vitk7_pkg::code1(p1, ns_s2_r[0])}]);
    cand0 = sum0[MW] ? '1 : sum0[MW-1:0];
    cand1 = sum1[MW] ? '1 : sum1[MW-1:0];
    // On a tie the predecessor with its high bit set survives.
    take_low = cand0 < cand1;
    sel_pm   = take_low ? cand0 : cand1;
  end

  // Survivor store: one entry per state per row; rows never written read as zero.
  logic [SW-1:0] surv_mem [TRACEBACK_DEPTH*vitk7_pkg::NST];
  logic [RW-1:0] tb_pi_r;
  logic [SW-1:0] tb_rd_r;
  logic tb_vld_r;
  logic [SW-1:0] tb_st;

  assign tb_st = tb_vld_r ? tb_rd_r : '0;

  always_ff @(posedge clk) begin
    nx_s3_r <= sel_pm;
    ns_s3_r <= ns_s2_r;
    if (v_s2_r) begin
      surv_mem[{row_r, ns_s2_r}] <= take_low ? p0 : p1;
    end
    if (v_s3_r) begin
      pm_mem[{~bank_r, ns_s3_r}] <= nx_s3_r;
    end
    if (cmd.tb_step) begin
      tb_rd_r <= surv_mem[{tb_pi_r, tb_st}];
    end
    if (cmd.out_load) begin
      out_bit <= tb_st[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r      <= 1'b0;
      v_s2_r      <= 1'b0;
      v_s3_r      <= 1'b0;
      bank_r      <= 1'b0;
      fresh_r     <= 1'b1;
      min_prev_r  <= '0;
      min_acc_r   <= '0;
      row_r       <= '0;
      row_valid_r <= '0;
      tb_pi_r     <= '0;
      tb_vld_r    <= 1'b0;
    end else begin
      v_s1_r <= cmd.acs_valid;
      v_s2_r <= v_s1_r;
      v_s3_r <= v_s2_r;
      if (v_s3_r && ((ns_s3_r == '0) || (nx_s3_r < min_acc_r))) begin
        min_acc_r <= nx_s3_r;
      end
      if (cmd.acs_done) begin
        bank_r             <= ~bank_r;
        fresh_r            <= 1'b0;
        min_prev_r         <= min_acc_r;
        row_valid_r[row_r] <= 1'b1;
        tb_pi_r            <= row_r;
        tb_vld_r           <= 1'b0;
      end
      if (cmd.tb_step) begin
        tb_vld_r <= row_valid_r[tb_pi_r];
        tb_pi_r  <= (tb_pi_r == '0) ? RW'(TRACEBACK_DEPTH - 1) : tb_pi_r - 1'b1;
      end
      if (cmd.out_load) begin
        row_r <= (row_r == RW'(TRACEBACK_DEPTH - 1)) ? '0 : row_r + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/viterbi_k7_rate_half_decoder_core.sv
// Soft-decision Viterbi decoder for the 64-state, rate one-half convolutional code
// (code bits u^p1^p2^p4^p5 and u^p0^p1^p2^p5). Each input transaction carries one
// I/Q sample pair and produces exactly one output transaction with the bit decided
// TRACEBACK_DEPTH symbols back. One item passes in order through the idle state, in which
// the pair is captured, the squared-distance and branch-metric states, the issue of all
// 64 states to the single pipelined add-compare-select unit, the drain of that unit,
// TRACEBACK_DEPTH dependent reads of the survivor memory and the load of the result.
// Only one symbol is in work at a time; the next transaction can be accepted in the cycle
// after the load. The input accepts a new transaction as soon as the previous symbol
// is finished, even while its result still waits in the output register; a symbol
// whose result finds that register still full holds in its load cycle until the
// sink takes the older result. There is no clearing pass after reset; rows of the
// survivor ring carry valid bits. Configuration (signal_gain at index 0,
// one_maps_negative at index 1) is written through cfg_we/cfg_index/cfg_wdata; the
// user must write it only while the decoder is idle, which the block does not enforce.
// Depends on vitk7_pkg, vitk7_in_if, vitk7_out_if, vitk7_ctrl and vitk7_dp.
`default_nettype none
module viterbi_k7_rate_half_decoder_core #(
  parameter int TRACEBACK_DEPTH = 64,
  parameter int METRIC_WIDTH    = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  vitk7_in_if.sink                              in_ch,
  vitk7_out_if.source                           out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [vitk7_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vitk7_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  vitk7_pkg::dp_cmd_t cmd;
  logic in_ready;
  logic out_valid;
  logic out_bit;

  // The controller sequences a symbol; it never looks at data.
  vitk7_ctrl #(
    .TRACEBACK_DEPTH(TRACEBACK_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd)
  );

  // The datapath holds metrics, survivors, traceback and the result bit.
  vitk7_dp #(
    .TRACEBACK_DEPTH(TRACEBACK_DEPTH),
    .METRIC_WIDTH   (METRIC_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_i     (in_ch.i_sample),
    .in_q     (in_ch.q_sample),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .out_bit  (out_bit)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.decoded_bit = out_bit;

  // One symbol at a time: after an accepted transaction the input stays closed.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a symbol is in work");

  // ACS issue and traceback never overlap.
  a_acs_tb_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.acs_valid && cmd.tb_step))
    else $error("ACS and traceback active together");

  // A result is only loaded into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten before delivery");

endmodule
`default_nettype wire

// File: dv/viterbi_k7_rate_half_decoder_core_tb.sv
// Self-checking testbench for the K=7 rate one-half soft-decision Viterbi decoder core.
// Depends on the RTL core, vitk7_pkg, vitk7_in_if, vitk7_out_if; holds its own decoder model.
`timescale 1ns / 1ps
module viterbi_k7_rate_half_decoder_core_tb;

  localparam int DEPTH     = 64;
  localparam int MET_W     = 24;
  localparam longint MET_MAX = (64'd1 << MET_W) - 1;
  localparam int N_PHASES  = 8;
  localparam int PHASE_ITEMS = 230;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [vitk7_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vitk7_pkg::CFG_DATA_W-1:0] cfg_wdata;

  vitk7_in_if  in_ch ();
  vitk7_out_if out_ch ();

  viterbi_k7_rate_half_decoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Model state: the testbench's own copy of the decoder's registers and memories.
  logic [vitk7_pkg::GAIN_W-1:0] gain;
  logic                         one_neg;
  longint                       metric [vitk7_pkg::NST];
  logic [vitk7_pkg::ST_W-1:0]   surv [DEPTH][vitk7_pkg::NST];
  int                           row;

  // Decoded bits still owed by the decoder, oldest first.
  bit  decoded_fifo [$];
  int  errors;
  bit  sender_done;

  // Directed rows: exp_bit of -1 means the bit comes from the model.
  typedef struct {
    int i_val;
    int q_val;
    int exp_bit;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{-128, -128, 0},      // first decision after reset always traces into never-written rows
    '{ 127,  127, -1},
    '{-128,  127, -1},
    '{ 127, -128, -1},
    '{   0,    0, -1},     // zero samples give all four branch metrics the same value
    '{   0,    0, -1},
    '{  64,   64, -1},
    '{ -64,  -64, -1},
    '{  64,  -64, -1},
    '{ -64,   64, -1},
    '{  -1,    1, -1},
    '{   1,   -1, -1},
    '{ 127,  127, -1},
    '{-128, -128, -1},
    '{  85, -170 + 42, -1},
    '{ -85,   42, -1},
    '{  -1,   -1, -1},
    '{   0,  127, -1},
    '{-128,    0, -1},
    '{  63,  -63, -1}
  };

  function automatic int ideal_level(input logic code_bit);
    int g;
    g = int'(gain);
    return (code_bit == one_neg) ? -g : g;
  endfunction

  // One trellis step of the decoder; returns the bit decided DEPTH symbols back.
  function automatic bit decode_step(input int iv, input int qv);
    longint nxt [vitk7_pkg::NST];
    longint cand [2];
    longint lowest;
    logic [vitk7_pkg::ST_W-1:0] p;
    logic [vitk7_pkg::ST_W-1:0] st;
    logic c1, c2;
    int di, dq, pr;
    for (int ns = 0; ns < vitk7_pkg::NST; ns++) begin
      for (int h = 0; h < 2; h++) begin
        p = {h[0], 5'(ns >> 1)};
        c1 = ns[0] ^ p[1] ^ p[2] ^ p[4] ^ p[5];
        c2 = ns[0] ^ p[0] ^ p[1] ^ p[2] ^ p[5];
        di = iv - ideal_level(c1);
        dq = qv - ideal_level(c2);
        cand[h] = metric[p] + longint'(di * di) + longint'(dq * dq);
        if (cand[h] > MET_MAX) cand[h] = MET_MAX;
      end
      // On a tie the predecessor with the high state bit set survives.
      if (cand[0] < cand[1]) begin
        nxt[ns] = cand[0];
        surv[row][ns] = 6'(ns >> 1);
      end else begin
        nxt[ns] = cand[1];
        surv[row][ns] = 6'(32 | (ns >> 1));
      end
    end
    st = '0;
    pr = row;
    for (int k = 0; k < DEPTH; k++) begin
      st = surv[pr][st];
      pr = (pr == 0) ? DEPTH - 1 : pr - 1;
    end
    row = (row + 1) % DEPTH;
    lowest = nxt[0];
    for (int ns = 1; ns < vitk7_pkg::NST; ns++) if (nxt[ns] < lowest) lowest = nxt[ns];
    for (int ns = 0; ns < vitk7_pkg::NST; ns++) metric[ns] = nxt[ns] - lowest;
    return st[0];
  endfunction

  task automatic write_reg(input logic [vitk7_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = vitk7_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == vitk7_pkg::REG_SIGNAL_GAIN) gain = vitk7_pkg::GAIN_W'(val);
    else one_neg = val[0];
  endtask

  // Sender pause: mostly back to back, sometimes a short gap, rarely a long gap.
  task automatic sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    if (r < 95) repeat ($urandom_range(1, 6)) @(negedge clk);
    else repeat ($urandom_range(20, 300)) @(negedge clk);
  endtask

  // Drives one I/Q transaction and records its expected decision once accepted.
  task automatic send_pair(input int iv, input int qv, input int exp_bit);
    bit predicted;
    sender_gap();
    in_ch.valid    = 1'b1;
    in_ch.i_sample = 8'(iv);
    in_ch.q_sample = 8'(qv);
    do @(posedge clk); while (!in_ch.ready);
    predicted = decode_step(iv, qv);
    decoded_fifo.push_back((exp_bit < 0) ? predicted : exp_bit[0]);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (decoded_fifo.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic int clamp8(input int v);
    return (v > 127) ? 127 : (v < -128) ? -128 : v;
  endfunction

  // Encoded bursts with random information bits and noise keep the survivors meaningful;
  // some items are raw random samples that break up the code sequence.
  task automatic random_phase(input int n_items);
    logic [vitk7_pkg::ST_W-1:0] enc;
    logic u, c1, c2;
    int noise, iv, qv, left, burst;
    enc  = '0;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 80);
      noise = $urandom_range(0, 3) == 0 ? $urandom_range(0, 128) : $urandom_range(0, 24);
      for (int k = 0; k < burst && left > 0; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          iv = int'($signed(8'($urandom)));
          qv = int'($signed(8'($urandom)));
        end else begin
          u  = 1'($urandom_range(0, 1));
          c1 = u ^ enc[1] ^ enc[2] ^ enc[4] ^ enc[5];
          c2 = u ^ enc[0] ^ enc[1] ^ enc[2] ^ enc[5];
          enc = {enc[4:0], u};
          iv = clamp8(ideal_level(c1) + $urandom_range(0, 2 * noise) - noise);
          qv = clamp8(ideal_level(c2) + $urandom_range(0, 2 * noise) - noise);
        end
        send_pair(iv, qv, -1);
        left--;
      end
    end
  endtask

  // Result checker: every accepted decision is compared with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decoded_fifo.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0b", $time,
                 out_ch.decoded_bit);
        errors++;
      end else begin
        if (out_ch.decoded_bit !== decoded_fifo[0]) begin
          $display("%0t: decoded_bit mismatch, expected %0b, actual %0b", $time,
                   decoded_fifo[0], out_ch.decoded_bit);
          errors++;
        end
        void'(decoded_fifo.pop_front());
      end
    end
  end

  // Receiver: alternates ready stretches with stalls; some stretches never stall.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ch.ready = 1'b1;
      repeat ($urandom_range(1, 400)) @(negedge clk);
      if ($urandom_range(0, 3) != 0) begin
        out_ch.ready = 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 300)) @(negedge clk);
        else repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // Main sequence: reset, directed table at reset settings, then random phases,
  // each starting with new register values written while the decoder is idle.
  initial begin
    int g_set [N_PHASES] = '{127, 1, 0, 127, 64, 0, 0, 0};
    int p_set [N_PHASES] = '{0, 1, 0, 1, 0, 0, 0, 0};
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.i_sample = '0;
    in_ch.q_sample = '0;
    errors = 0;
    sender_done = 1'b0;
    gain = vitk7_pkg::GAIN_RESET;
    one_neg = 1'b1;
    row = 0;
    for (int s = 0; s < vitk7_pkg::NST; s++) metric[s] = 0;
    for (int r = 0; r < DEPTH; r++)
      for (int s = 0; s < vitk7_pkg::NST; s++) surv[r][s] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[k]) send_pair(dir_rows[k].i_val, dir_rows[k].q_val, dir_rows[k].exp_bit);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // The decoder must be idle before its registers change.
      wait_drained();
      if (ph >= 5) begin
        g_set[ph] = $urandom_range(0, 127);
        p_set[ph] = $urandom_range(0, 1);
      end
      write_reg(vitk7_pkg::REG_SIGNAL_GAIN, g_set[ph]);
      write_reg(vitk7_pkg::REG_ONE_MAPS_NEG, p_set[ph]);
      random_phase(PHASE_ITEMS);
    end
    sender_done = 1'b1;
  end

  // End of run: all owed results in, then a quiet stretch before the verdict.
  initial begin
    wait (sender_done);
    while (decoded_fifo.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Timeout at %0t with %0d results outstanding", $time, decoded_fifo.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
